>>> hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> hw/rtl/toi_pkg.sv
`timescale 1ns / 1ps
package toi_pkg;
  localparam logic [1:0] REQ_WR_DIST = 2'd0;
  localparam logic [1:0] REQ_WR_TOUR = 2'd1;
  localparam logic [1:0] REQ_RUN     = 2'd2;
  localparam logic [1:0] REQ_RD_TOUR = 2'd3;
  localparam int MAX_CITIES = 256;
  localparam int DIST_WIDTH = 32;
  localparam int unsigned LEN_W = 40;
  localparam int unsigned MOVES_W = 10;
  localparam int unsigned CITY_W = 8;
  // 76 field bits padded to whole bytes
  localparam int unsigned IN_W = 80;
  localparam int unsigned OUT_W = 8 + 10 + 40;
  typedef logic [LEN_W-1:0] len_t;
endpackage

>>> hw/rtl/toi_ram.sv
`timescale 1ns / 1ps
module toi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/two_opt_tour_improver_top.sv
`timescale 1ns / 1ps
// Two-opt tour improver.
// s_axis carries requests: write distance, write tour slot, run, read slot.
// m_axis returns one result per request. cfg_we/cfg_data set city_count.
// A request is taken whenever the sequencer is idle, one at a time. A write
// request goes through S_DONE, a read request through S_RD, S_RDW and S_DONE,
// where its result is registered on m_axis; the next request waits for idle.
// A run scans pairs (i,k), reading four tour slots in S_TR and four distances
// in S_DIST through one read port per memory and comparing them in S_CMP; a
// reversal swaps slot pairs in S_REV, and the closing length sum walks the
// tour in S_LEN and S_LD. Total run time is data dependent and quadratic.
// Reset clears control state and city_count; the stores are not cleared.
// When the receiver stalls, a result holds in m_axis_tdata; one more request
// may still be taken and processed, and its result waits until the output
// drains.
module two_opt_tour_improver_top import toi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // req_type, from_city, to_city, distance_value, tour_position, city_id,
  // pass_limit, 4 pad bits
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_city, moves_done, tour_length, 6 pad bits
  output logic [63:0]         m_axis_tdata
);
  localparam int AW = $clog2(MAX_CITIES);
  localparam int CW = AW + 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_PAIR = 4'd2,
    S_TR = 4'd3, S_DIST = 4'd4, S_CMP = 4'd5, S_REV = 4'd6, S_LEN = 4'd7,
    S_LD = 4'd8, S_DONE = 4'd9, S_RDW = 4'd10;

  logic [3:0] state;
  logic [8:0] city_count;
  logic [CW-1:0] n, i, k, lo, hi, s;
  logic [9:0] limit, passes;
  logic [MOVES_W-1:0] moves;
  logic [2:0] sub;
  logic [CITY_W-1:0] cp, ci, ck, cq, tmp;
  logic [DIST_WIDTH:0] added, removed;
  len_t len;
  logic [7:0] rdc;
  logic [CW-1:0] tpos;

  logic [1:0] rq;
  logic [7:0] f_from, f_to, f_pos, f_cid;
  logic [31:0] f_dist;
  logic [9:0] f_lim;
  assign {f_lim, f_cid, f_pos, f_dist, f_to, f_from, rq} = s_axis_tdata[75:0];

  logic t_we; logic [AW-1:0] t_wa, t_ra; logic [7:0] t_wd, t_rd;
  logic d_we; logic [2*AW-1:0] d_wa, d_ra; logic [DIST_WIDTH-1:0] d_wd, d_rd;
  toi_ram #(.WIDTH(8), .DEPTH(MAX_CITIES)) u_tour (.clk, .we(t_we),
    .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  toi_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_CITIES*MAX_CITIES)) u_dist (.clk,
    .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));

  logic acc;
  assign s_axis_tready = (state == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  logic from_ok, to_ok, pos_ok;
  assign from_ok = {1'b0, f_from} < 9'(MAX_CITIES);
  assign to_ok = {1'b0, f_to} < 9'(MAX_CITIES);
  assign pos_ok = {1'b0, f_pos} < 9'(MAX_CITIES);

  // distance lookup address of a city pair; out-of-range gives zero
  logic da_ok;
  logic [7:0] da_a, da_b;
  always_comb begin
    unique case (sub[1:0])
      2'd0: begin da_a = cp; da_b = ck; end
      2'd1: begin da_a = ci; da_b = cq; end
      2'd2: begin da_a = cp; da_b = ci; end
      default: begin da_a = ck; da_b = cq; end
    endcase
    if (state == S_LEN || state == S_LD) begin da_a = cp; da_b = ci; end
    da_ok = ({1'b0, da_a} < 9'(MAX_CITIES)) && ({1'b0, da_b} < 9'(MAX_CITIES));
    d_ra = {da_a[AW-1:0], da_b[AW-1:0]};
  end
  logic da_ok_q;
  logic [DIST_WIDTH-1:0] dv;
  assign dv = da_ok_q ? d_rd : '0;

  assign d_we = acc && rq == REQ_WR_DIST && from_ok && to_ok;
  assign d_wa = {f_from[AW-1:0], f_to[AW-1:0]};
  assign d_wd = f_dist[DIST_WIDTH-1:0];

  logic [CW-1:0] q_idx, s_nx;
  assign q_idx = (k + 1'b1 == n) ? '0 : k + 1'b1;
  assign s_nx = (s + 1'b1 == n) ? '0 : s + 1'b1;

  always_comb begin
    t_we = 1'b0; t_wa = f_pos[AW-1:0]; t_wd = f_cid; t_ra = f_pos[AW-1:0];
    if (acc && rq == REQ_WR_TOUR && pos_ok) t_we = 1'b1;
    unique case (state)
      S_RD: t_ra = AW'(tpos);
      S_TR: unique case (sub[1:0])
        2'd0: t_ra = AW'(i - 1'b1);
        2'd1: t_ra = AW'(i);
        2'd2: t_ra = AW'(k);
        default: t_ra = AW'(q_idx);
      endcase
      S_REV: begin
        t_ra = sub[0] ? AW'(hi) : AW'(lo);
        if (sub == 3'd2) begin t_we = 1'b1; t_wa = AW'(lo); t_wd = t_rd; end
        if (sub == 3'd3) begin t_we = 1'b1; t_wa = AW'(hi); t_wd = tmp; end
      end
      S_LEN: t_ra = sub[0] ? AW'(s_nx) : AW'(s);
      default: ;
    endcase
  end

  logic [DIST_WIDTH:0] lhs;
  len_t len_sum;
  assign lhs = added;
  assign len_sum = len + LEN_W'(dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; city_count <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      da_ok_q <= da_ok;
      if (cfg_we) city_count <= cfg_data;
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc) begin
          rdc <= '0; moves <= '0; len <= '0; tpos <= CW'(f_pos);
          unique case (rq)
            REQ_RUN: begin
              n <= (city_count > 9'(MAX_CITIES)) ? CW'(MAX_CITIES) : CW'(city_count);
              limit <= f_lim; passes <= '0; state <= S_PAIR;
              i <= CW'(1); k <= CW'(2);
            end
            REQ_RD_TOUR: state <= S_RD;
            default: state <= S_DONE;
          endcase
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          rdc <= (tpos < CW'(MAX_CITIES)) ? t_rd : '0; state <= S_DONE;
        end
        S_PAIR: begin
          sub <= '0; added <= '0; removed <= '0;
          if (n < CW'(4) || passes == limit) begin
            state <= S_LEN; s <= '0;
          end else begin
            i <= CW'(1); k <= CW'(2); state <= S_TR;
          end
        end
        S_TR: begin
          unique case (sub)
            3'd1: cp <= t_rd;
            3'd2: ci <= t_rd;
            3'd3: ck <= t_rd;
            3'd4: cq <= t_rd;
            default: ;
          endcase
          if (sub == 3'd4) begin sub <= '0; state <= S_DIST; end
          else sub <= sub + 1'b1;
        end
        S_DIST: begin
          sub <= sub + 1'b1;
          if (sub >= 3'd1 && sub <= 3'd2) added <= added + (DIST_WIDTH+1)'(dv);
          if (sub >= 3'd3) removed <= removed + (DIST_WIDTH+1)'(dv);
          if (sub == 3'd4) state <= S_CMP;
        end
        S_CMP: begin
          sub <= '0; added <= '0; removed <= '0;
          if (lhs < removed) begin
            lo <= i; hi <= k; state <= S_REV;
          end else if (k + 1'b1 < n) begin
            k <= k + 1'b1; state <= S_TR;
          end else if (i + CW'(2) < n) begin
            i <= i + 1'b1; k <= i + CW'(2); state <= S_TR;
          end else begin
            state <= S_LEN; s <= '0;
          end
        end
        S_REV: begin
          if (sub == 3'd0 && !(lo < hi)) begin
            moves <= moves + 1'b1; passes <= passes + 1'b1; state <= S_PAIR;
          end
          if (sub == 3'd1) tmp <= t_rd;
          if (sub == 3'd3) begin lo <= lo + 1'b1; hi <= hi - 1'b1; sub <= '0; end
          else sub <= sub + 1'b1;
        end
        S_LEN: begin
          if (n == '0) state <= S_DONE;
          else if (sub == 3'd1) begin cp <= t_rd; sub <= sub + 1'b1; end
          else if (sub == 3'd2) begin ci <= t_rd; state <= S_LD; sub <= '0; end
          else sub <= sub + 1'b1;
        end
        S_LD: begin
          if (sub == 3'd1) begin
            len <= (len_sum < len) ? '1 : len_sum; sub <= '0;
            if (s + 1'b1 == n) state <= S_DONE;
            else begin s <= s + 1'b1; state <= S_LEN; end
          end else sub <= sub + 1'b1;
        end
        S_DONE: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {6'd0, len, moves, rdc}; m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/toi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module toi_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !m_axis_tvalid, "result valid after reset")
  `ASSERT_NEXT(a_one, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "two requests in flight")
endmodule
bind two_opt_tour_improver_top toi_checker u_chk (.*);

>>> verif/tb_two_opt_tour_improver_top.sv
`timescale 1ns / 1ps
module tb_two_opt_tour_improver_top;
  import toi_pkg::*;

  localparam int NCITY = 256;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct {
    logic [7:0]       rd;
    logic [9:0]       moves;
    logic [LEN_W-1:0] len;
  } result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [8:0]      cfg_data = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [63:0]     m_axis_tdata;

  two_opt_tour_improver_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // shadow copy of the block state
  logic [31:0] dist_mem [int];
  logic [7:0]  tour_mem [NCITY];
  bit          tour_valid [NCITY];
  int          n_cities = 0;
  logic [7:0]  pool [$];
  result_t     pending [$];
  int          errors = 0;
  longint      cycles = 0;
  bit          rx_stall_en = 1'b1;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [9:0] rnd10();
    return 10'($urandom);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_dist();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 4095);
    if (r < 8) return $urandom;
    if (r < 9) return 32'd0;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [63:0] d(logic [7:0] a, logic [7:0] b);
    return {32'd0, dist_mem[{a, b}]};
  endfunction

  function automatic logic [63:0] tour_len(int n);
    logic [63:0] sum;
    sum = 0;
    for (int s = 0; s < n; s++) begin
      sum += d(tour_mem[s], tour_mem[(s + 1 == n) ? 0 : s + 1]);
      if (sum > 64'hFF_FFFF_FFFF) sum = 64'hFF_FFFF_FFFF;
    end
    return sum;
  endfunction

  function automatic bit improve_once(int n);
    logic [7:0] cp, ci, ck, cq, t;
    int lo, hi;
    for (int i = 1; i + 1 < n; i++)
      for (int k = i + 1; k < n; k++) begin
        cp = tour_mem[i-1]; ci = tour_mem[i]; ck = tour_mem[k];
        cq = tour_mem[(k + 1 == n) ? 0 : k + 1];
        if (d(cp, ck) + d(ci, cq) < d(cp, ci) + d(ck, cq)) begin
          lo = i; hi = k;
          while (lo < hi) begin
            t = tour_mem[lo]; tour_mem[lo] = tour_mem[hi]; tour_mem[hi] = t;
            lo++; hi--;
          end
          return 1'b1;
        end
      end
    return 1'b0;
  endfunction

  function automatic void predict(logic [1:0] kind, logic [7:0] from_c, logic [7:0] to_c,
                                  logic [31:0] dv, logic [7:0] pos, logic [7:0] cid,
                                  logic [9:0] lim);
    result_t r;
    int n;
    r = '{rd: '0, moves: '0, len: '0};
    case (kind)
      REQ_WR_DIST: dist_mem[{from_c, to_c}] = dv;
      REQ_WR_TOUR: begin
        tour_mem[pos] = cid;
        tour_valid[pos] = 1'b1;
      end
      REQ_RUN: begin
        n = (n_cities > NCITY) ? NCITY : n_cities;
        if (n >= 4)
          for (int p = 0; p < lim; p++) begin
            if (!improve_once(n)) break;
            r.moves++;
          end
        r.len = LEN_W'(tour_len(n));
      end
      default: r.rd = tour_mem[pos];
    endcase
    pending = {pending, r};
  endfunction

  task automatic send_req(logic [1:0] kind, logic [7:0] from_c, logic [7:0] to_c,
                          logic [31:0] dv, logic [7:0] pos, logic [7:0] cid,
                          logic [9:0] lim);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata = {4'd0, lim, cid, pos, dv, to_c, from_c, kind};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict(kind, from_c, to_c, dv, pos, cid, lim);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_city_count(int n);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = n[8:0];
    @(negedge clk);
    cfg_we = 1'b0;
    n_cities = n;
  endtask

  task automatic mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver stall pattern
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        g = gap_len();
        repeat (g) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        mismatch("unexpected result", m_axis_tdata, 64'd0);
      end else begin
        w = pending.pop_front();
        if (m_axis_tdata[7:0] !== w.rd)
          mismatch("read_city", 64'(m_axis_tdata[7:0]), 64'(w.rd));
        if (m_axis_tdata[17:8] !== w.moves)
          mismatch("moves_done", 64'(m_axis_tdata[17:8]), 64'(w.moves));
        if (m_axis_tdata[57:18] !== w.len)
          mismatch("tour_length", 64'(m_axis_tdata[57:18]), 64'(w.len));
      end
    end
  end

  // complete distance matrix over a city pool, then a tour over the first n slots
  task automatic load_tour(int n, int m);
    logic [7:0] c;
    pool.delete();
    for (int j = 0; j < m; j++) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) c = (j % 2) ? 8'hFF : 8'h00;
      pool = {pool, c};
    end
    foreach (pool[a]) foreach (pool[b])
      send_req(REQ_WR_DIST, pool[a], pool[b], rand_dist(), rnd8(), rnd8(), rnd10());
    for (int s = 0; s < n; s++)
      send_req(REQ_WR_TOUR, rnd8(), rnd8(), $urandom, s[7:0],
               pool[$urandom_range(0, m - 1)], rnd10());
  endtask

  function automatic logic [9:0] rand_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 10'($urandom_range(0, 1023));
    if (r < 8) return 10'($urandom_range(0, 3));
    return 10'h3FF;
  endfunction

  task automatic test_small_tours();
    for (int n = 0; n < 4; n++) begin
      set_city_count(n);
      load_tour(n, 3);
      send_req(REQ_RUN, rnd8(), rnd8(), $urandom, rnd8(), rnd8(), 10'h3FF);
    end
  endtask

  task automatic test_four_city_edges();
    set_city_count(4);
    load_tour(4, 4);
    send_req(REQ_RUN, 8'h00, 8'h00, 32'd0, 8'h00, 8'h00, 10'd0);
    send_req(REQ_RUN, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 10'd1);
    send_req(REQ_RUN, rnd8(), rnd8(), $urandom, rnd8(), rnd8(), 10'h3FF);
    for (int s = 0; s < 4; s++)
      send_req(REQ_RD_TOUR, rnd8(), rnd8(), $urandom, s[7:0], rnd8(), rnd10());
  endtask

  // every slot holds the same city: one full scan without a move
  task automatic test_full_tour();
    logic [7:0] c;
    c = rnd8();
    set_city_count(NCITY);
    send_req(REQ_WR_DIST, c, c, 32'hFFFF_FFFF, rnd8(), rnd8(), rnd10());
    for (int s = 0; s < NCITY; s++)
      send_req(REQ_WR_TOUR, rnd8(), rnd8(), $urandom, s[7:0], c, rnd10());
    send_req(REQ_RUN, rnd8(), rnd8(), $urandom, rnd8(), rnd8(), 10'h3FF);
    send_req(REQ_RD_TOUR, rnd8(), rnd8(), $urandom, 8'hFF, rnd8(), rnd10());
  endtask

  task automatic test_random_phases(int total);
    int sent, n, r, m;
    logic [7:0] pos;
    sent = 0;
    while (sent < total) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 8);
      m = $urandom_range(2, 5);
      rx_stall_en = ($urandom_range(0, 4) != 0);
      set_city_count(n);
      load_tour(n, m);
      sent += m * m + n;
      repeat ($urandom_range(20, 50)) begin
        r = $urandom_range(0, 99);
        pos = rnd8();
        if (r < 20) begin
          send_req(REQ_RUN, rnd8(), rnd8(), $urandom, rnd8(), rnd8(), rand_limit());
        end else if (r < 45) begin
          while (!tour_valid[pos]) pos = rnd8();
          send_req(REQ_RD_TOUR, rnd8(), rnd8(), $urandom, pos, rnd8(), rnd10());
        end else if (r < 70) begin
          if (n > 0 && $urandom_range(0, 4) != 0)
            send_req(REQ_WR_TOUR, rnd8(), rnd8(), $urandom, 8'($urandom_range(0, n - 1)),
                     pool[$urandom_range(0, m - 1)], rnd10());
          else
            send_req(REQ_WR_TOUR, rnd8(), rnd8(), $urandom,
                     8'($urandom_range(n, 255)), rnd8(), rnd10());
        end else if ($urandom_range(0, 6) != 0) begin
          send_req(REQ_WR_DIST, pool[$urandom_range(0, m - 1)], pool[$urandom_range(0, m - 1)],
                   rand_dist(), rnd8(), rnd8(), rnd10());
        end else begin
          send_req(REQ_WR_DIST, rnd8(), rnd8(), rand_dist(), rnd8(), rnd8(), rnd10());
        end
        sent++;
      end
    end
    rx_stall_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_small_tours();
    test_four_city_edges();
    test_full_tour();
    test_random_phases(1000);
    drain();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
